// File: hdl/swq_pkg.sv
// Shared types, constants and helpers for the station waiting queue.
// Used by every module of the block but the entry RAM, and by its port checker.
package swq_pkg;

  // Sizes of the queue bank.
  localparam int NUM_QUEUES  = 16;
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 10;

  // Field widths.
  localparam int ACT_W    = 2;
  localparam int QIDX_W   = 4;
  localparam int TIME_W   = 32;
  localparam int STAT_W   = 3;
  localparam int QLEN_W   = 5;
  localparam int CNT_W    = 5;
  localparam int LEN_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W   = $clog2(NUM_QUEUES * QUEUE_DEPTH);

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PEEK   = 2'd2;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_DONE     = 3'd0,
    STAT_BADQ     = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_DUP      = 3'd3,
    STAT_NOTFOUND = 3'd4,
    STAT_EMPTY    = 3'd5
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_SHIFT,
    S_HEAD_RD,
    S_HEAD_WAIT,
    S_FINISH
  } state_t;

  // One input item, first field in the highest bits.
  typedef struct packed {
    logic [TIME_W-1:0]  arrival_time;
    logic [ID_BITS-1:0] client_id;
    logic [QIDX_W-1:0]  queue_index;
    logic [ACT_W-1:0]   action;
  } item_t;

  // One result item, first field in the highest bits.
  typedef struct packed {
    logic [QLEN_W-1:0]  queue_length;
    logic [TIME_W-1:0]  head_time;
    logic [ID_BITS-1:0] head_id;
    logic               head_valid;
    status_t            status;
  } result_t;

  // One stored list entry.
  typedef struct packed {
    logic [TIME_W-1:0]  arrival_time;
    logic [ID_BITS-1:0] client_id;
  } entry_t;

  localparam int IN_TDATA_W  = (($bits(item_t) + 7) / 8) * 8;
  localparam int OUT_TDATA_W = (($bits(result_t) + 7) / 8) * 8;
  localparam int ENTRY_W     = $bits(entry_t);

  // Entry memory access from the sequencer.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
  } ram_req_t;

  // Memory address of slot p of list q.
  function automatic logic [ADDR_W-1:0] entry_addr(logic [QIDX_W-1:0] q,
                                                   logic [LEN_W-1:0] p);
    return ADDR_W'(int'(q) * QUEUE_DEPTH + int'(p));
  endfunction

endpackage

// File: hdl/swq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; holds the list entries of the station waiting queue.
module swq_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 42
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/swq_len_table.sv
// Per-list length table of the station waiting queue, cleared by reset.
// Depends on swq_pkg.
module swq_len_table
  import swq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [QIDX_W-1:0] rd_q,
  output logic [LEN_W-1:0]  rd_len,
  input  logic              wr_en,
  input  logic [QIDX_W-1:0] wr_q,
  input  logic [LEN_W-1:0]  wr_len
);

  logic [LEN_W-1:0] len_r [NUM_QUEUES];

  // Lengths are control state and start at zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        len_r[i] <= '0;
      end
    end else if (wr_en) begin
      len_r[wr_q] <= wr_len;
    end
  end

  assign rd_len = len_r[rd_q];

endmodule

// File: hdl/swq_ctrl.sv
// Sequencer of the station waiting queue: scans, appends, shifts and reads the
// head through the entry RAM. Depends on swq_pkg.
module swq_ctrl
  import swq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // Configuration
  input  logic              cfg_valid,
  input  logic [CNT_W-1:0]  cfg_data,
  // Input items
  input  logic              item_valid,
  output logic              item_ready,
  input  item_t             item,
  // Results
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res,
  // Entry RAM
  output ram_req_t          ram_req,
  input  entry_t            ram_rd_data,
  // Length table
  output logic [QIDX_W-1:0] tbl_rd_q,
  input  logic [LEN_W-1:0]  tbl_rd_len,
  output logic              tbl_wr_en,
  output logic [QIDX_W-1:0] tbl_wr_q,
  output logic [LEN_W-1:0]  tbl_wr_len
);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   qcount_r;
  logic [ACT_W-1:0]   act_r, act_nxt;
  logic [QIDX_W-1:0]  q_r, q_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [TIME_W-1:0]  time_r, time_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [LEN_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [LEN_W-1:0]   chk_ptr_r, chk_ptr_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  result_t            res_r, res_nxt;

  logic bad_q;
  logic hit;
  logic last;
  logic issue;
  logic is_add;
  logic is_remove;

  // Decode of the current operation.
  assign bad_q     = ({1'b0, q_r} >= qcount_r) ||
                     ({1'b0, q_r} >= CNT_W'(NUM_QUEUES));
  assign is_add    = (act_r == ACT_ADD);
  assign is_remove = (act_r == ACT_REMOVE);
  assign hit       = chk_vld_r && (ram_rd_data.client_id == id_r);
  assign last      = (chk_ptr_r == len_r - LEN_W'(1));
  assign issue     = (rd_ptr_r < len_r);

  assign tbl_rd_q   = q_r;
  assign item_ready = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_FINISH);
  assign res        = res_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (item_valid) state_nxt = S_START;
      end
      S_START: begin
        if (bad_q) begin
          state_nxt = S_FINISH;
        end else if (!is_add && !is_remove) begin
          state_nxt = S_HEAD_RD;
        end else if (tbl_rd_len == '0 || (is_add && tbl_rd_len >= LEN_W'(QUEUE_DEPTH))) begin
          state_nxt = S_HEAD_RD;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = (is_remove && !last) ? S_SHIFT : S_HEAD_RD;
        end else if (chk_vld_r && last) begin
          state_nxt = S_HEAD_RD;
        end
      end
      S_SHIFT: begin
        if (chk_vld_r && last) state_nxt = S_HEAD_RD;
      end
      S_HEAD_RD:   state_nxt = S_HEAD_WAIT;
      S_HEAD_WAIT: state_nxt = S_FINISH;
      S_FINISH: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory accesses per state.
  always_comb begin
    act_nxt     = act_r;
    q_nxt       = q_r;
    id_nxt      = id_r;
    time_nxt    = time_r;
    len_nxt     = len_r;
    rd_ptr_nxt  = rd_ptr_r;
    chk_ptr_nxt = chk_ptr_r;
    chk_vld_nxt = 1'b0;
    res_nxt     = res_r;
    ram_req     = '0;
    tbl_wr_en   = 1'b0;
    tbl_wr_q    = q_r;
    tbl_wr_len  = len_r;

    // Reads walk the list one slot per cycle; the compare follows in the next cycle.
    if (state_r == S_SCAN || state_r == S_SHIFT) begin
      if (issue) begin
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = entry_addr(q_r, rd_ptr_r);
        rd_ptr_nxt      = rd_ptr_r + LEN_W'(1);
        chk_ptr_nxt     = rd_ptr_r;
        chk_vld_nxt     = 1'b1;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (item_valid) begin
          act_nxt  = item.action;
          q_nxt    = item.queue_index;
          id_nxt   = item.client_id;
          time_nxt = item.arrival_time;
        end
      end
      S_START: begin
        len_nxt        = tbl_rd_len;
        rd_ptr_nxt     = '0;
        res_nxt.status = STAT_DONE;
        if (bad_q) begin
          res_nxt        = '0;
          res_nxt.status = STAT_BADQ;
        end else if (is_add) begin
          if (tbl_rd_len >= LEN_W'(QUEUE_DEPTH)) begin
            res_nxt.status = STAT_FULL;
          end else if (tbl_rd_len == '0) begin
            // Empty list: append without a search.
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = entry_addr(q_r, '0);
            ram_req.wr_data = '{arrival_time: time_r, client_id: id_r};
            len_nxt         = LEN_W'(1);
          end
        end else if (is_remove) begin
          if (tbl_rd_len == '0) res_nxt.status = STAT_NOTFOUND;
        end else if (tbl_rd_len == '0) begin
          res_nxt.status = STAT_EMPTY;
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (is_add) begin
            res_nxt.status = STAT_DUP;
          end else if (last) begin
            len_nxt = len_r - LEN_W'(1);
          end
          // A remove that is not at the tail goes on shifting; the read of the
          // next slot is already in flight.
        end else if (chk_vld_r && last) begin
          if (is_add) begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = entry_addr(q_r, len_r);
            ram_req.wr_data = '{arrival_time: time_r, client_id: id_r};
            len_nxt         = len_r + LEN_W'(1);
          end else begin
            res_nxt.status = STAT_NOTFOUND;
          end
        end
      end
      S_SHIFT: begin
        // Each slot moves down one place. The write trails the read by two
        // slots, so the two ports never touch the same entry in one cycle.
        if (chk_vld_r) begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = entry_addr(q_r, chk_ptr_r - LEN_W'(1));
          ram_req.wr_data = ram_rd_data;
          if (last) len_nxt = len_r - LEN_W'(1);
        end
      end
      S_HEAD_RD: begin
        tbl_wr_en       = 1'b1;
        ram_req.rd_en   = (len_r != '0);
        ram_req.rd_addr = entry_addr(q_r, '0);
      end
      S_HEAD_WAIT: begin
        res_nxt.head_valid   = (len_r != '0);
        res_nxt.head_id      = (len_r != '0) ? ram_rd_data.client_id : '0;
        res_nxt.head_time    = (len_r != '0) ? ram_rd_data.arrival_time : '0;
        res_nxt.queue_length = QLEN_W'(len_r);
      end
      S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      qcount_r  <= '0;
      chk_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      chk_vld_r <= chk_vld_nxt;
      if (cfg_valid) qcount_r <= cfg_data;
    end
  end

  // Operation and working registers.
  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    q_r       <= q_nxt;
    id_r      <= id_nxt;
    time_r    <= time_nxt;
    len_r     <= len_nxt;
    rd_ptr_r  <= rd_ptr_nxt;
    chk_ptr_r <= chk_ptr_nxt;
    res_r     <= res_nxt;
  end

endmodule

// File: hdl/station_waiting_queue.sv
// Station waiting queue: NUM_QUEUES ordered lists of client ids with arrival
// times, kept in one entry RAM with a small length table beside it. One item
// is worked on at a time. A bad queue goes from its start state straight to a
// result; a peek, a full add or an operation on an empty list reads the head
// without a scan. An add or remove on a non-empty list reads the list one entry
// per cycle through the RAM read port. A remove moves each later entry down one
// slot within that same pass. The worst case is a remove on a full list. The
// result sits in an output register, so the next item is accepted while the
// previous result waits. queue_count resets to zero: no queue is valid until
// it is written, and writes take effect at once. Depends on swq_pkg.
module station_waiting_queue
  import swq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration: queue_count
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CNT_W-1:0]       cfg_data,
  // Input items: action, queue_index, client_id, arrival_time
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // Result items: status, head_valid, head_id, head_time, queue_length, zero pad
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  item_t                  item;
  result_t                res;
  logic                   res_valid;
  logic                   res_ready;
  ram_req_t               ram_req;
  logic [ENTRY_W-1:0]     ram_rd_bits;
  logic [QIDX_W-1:0]      tbl_rd_q;
  logic [LEN_W-1:0]       tbl_rd_len;
  logic                   tbl_wr_en;
  logic [QIDX_W-1:0]      tbl_wr_q;
  logic [LEN_W-1:0]       tbl_wr_len;
  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  assign cfg_ready = 1'b1;
  assign item      = item_t'(in_tdata[$bits(item_t)-1:0]);

  swq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .item_valid  (in_tvalid),
    .item_ready  (in_tready),
    .item        (item),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .ram_req     (ram_req),
    .ram_rd_data (entry_t'(ram_rd_bits)),
    .tbl_rd_q    (tbl_rd_q),
    .tbl_rd_len  (tbl_rd_len),
    .tbl_wr_en   (tbl_wr_en),
    .tbl_wr_q    (tbl_wr_q),
    .tbl_wr_len  (tbl_wr_len)
  );

  swq_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (ram_rd_bits)
  );

  swq_len_table u_len (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_q   (tbl_rd_q),
    .rd_len (tbl_rd_len),
    .wr_en  (tbl_wr_en),
    .wr_q   (tbl_wr_q),
    .wr_len (tbl_wr_len)
  );

  // Output register: loads when empty or being drained.
  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_tdata_r <= OUT_TDATA_W'(res);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// File: hdl/swq_checker.sv
// Port checker for the station waiting queue, bound to the top level.
// Depends on swq_pkg and station_waiting_queue.
module swq_checker
  import swq_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  result_t res;
  assign res = result_t'(out_tdata[$bits(result_t)-1:0]);

  // The block takes one input item at a time.
  a_in_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input item accepted while another is in work");

  // A stalled result item holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // A rejected queue reports nothing else.
  a_badq_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.status == STAT_BADQ |->
      !res.head_valid && res.head_id == '0 && res.head_time == '0 &&
      res.queue_length == '0)
    else $error("bad queue result carries data");

  // The head is valid exactly when the list is not empty.
  a_head_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res.head_valid == (res.queue_length != '0))
    else $error("head_valid disagrees with queue_length");

  // An empty peek and a full add report consistent lengths.
  a_len_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res.status != STAT_EMPTY || res.queue_length == '0) &&
      (res.status != STAT_FULL || res.queue_length == QLEN_W'(QUEUE_DEPTH)))
    else $error("queue_length disagrees with status");

endmodule

bind station_waiting_queue swq_checker u_swq_checker (.*);

// File: tb/tb_station_waiting_queue.sv
// Self-checking testbench for the station waiting queue: a directed table,
// then random phases under several queue counts, checked against a predictor.
// Depends on swq_pkg and station_waiting_queue.
module tb_station_waiting_queue;
  import swq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The fourth action code is handled as a peek.
  localparam logic [ACT_W-1:0] ACT_PEEK_ALT = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT    = 37;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CNT_W-1:0]       cfg_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // action, queue_index, client_id, arrival_time
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // status, head_valid, head_id, head_time, queue_length

  station_waiting_queue uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // One row of the directed table: a register write or an item, optionally
  // repeated with the id and time stepped, and an optional typed-in result.
  typedef struct {
    bit               is_cfg;
    logic [CNT_W-1:0] count;
    item_t            item;
    int               reps;
    bit               typed;
    result_t          res;
  } plan_row_t;

  plan_row_t plan[$];
  result_t   expected_results[$];

  // Shadow copy of the queue bank.
  logic [ID_BITS-1:0] shadow_ids   [NUM_QUEUES][QUEUE_DEPTH];
  logic [TIME_W-1:0]  shadow_times [NUM_QUEUES][QUEUE_DEPTH];
  int                 shadow_len   [NUM_QUEUES];
  int                 shadow_count;

  int      errors;
  int      cycles;
  bit      calm;
  result_t mon_got;
  result_t mon_want;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Applies one operation to the shadow bank and returns its result.
  function automatic result_t predict_queue_op(item_t it);
    result_t r;
    int      q;
    int      n;
    int      pos;
    r = '0;
    q = int'(it.queue_index);
    if (q >= shadow_count || q >= NUM_QUEUES) begin
      r.status = STAT_BADQ;
      return r;
    end
    n = shadow_len[q];
    case (it.action)
      ACT_ADD: begin
        if (n >= QUEUE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          r.status = STAT_DONE;
          for (int i = 0; i < n; i++)
            if (shadow_ids[q][i] == it.client_id) r.status = STAT_DUP;
          if (r.status == STAT_DONE) begin
            shadow_ids[q][n]   = it.client_id;
            shadow_times[q][n] = it.arrival_time;
            n++;
          end
        end
      end
      ACT_REMOVE: begin
        pos = -1;
        for (int i = n - 1; i >= 0; i--)
          if (shadow_ids[q][i] == it.client_id) pos = i;
        if (pos < 0) begin
          r.status = STAT_NOTFOUND;
        end else begin
          // Close the gap so the remaining entries keep their order.
          for (int j = pos; j + 1 < n; j++) begin
            shadow_ids[q][j]   = shadow_ids[q][j+1];
            shadow_times[q][j] = shadow_times[q][j+1];
          end
          n--;
          r.status = STAT_DONE;
        end
      end
      default: begin
        r.status = (n == 0) ? STAT_EMPTY : STAT_DONE;
      end
    endcase
    shadow_len[q] = n;
    if (n > 0) begin
      r.head_valid = 1'b1;
      r.head_id    = shadow_ids[q][0];
      r.head_time  = shadow_times[q][0];
    end
    r.queue_length = QLEN_W'(n);
    return r;
  endfunction

  function automatic result_t mk_result(status_t st, logic hv, logic [ID_BITS-1:0] id,
                                        logic [TIME_W-1:0] t, logic [QLEN_W-1:0] len);
    result_t r;
    r.status       = st;
    r.head_valid   = hv;
    r.head_id      = id;
    r.head_time    = t;
    r.queue_length = len;
    return r;
  endfunction

  function automatic void plan_cfg(logic [CNT_W-1:0] count);
    plan_row_t row;
    row        = '{default: '0};
    row.is_cfg = 1'b1;
    row.count  = count;
    plan.push_back(row);
  endfunction

  function automatic void plan_item(logic [ACT_W-1:0] act, logic [QIDX_W-1:0] q,
                                    logic [ID_BITS-1:0] id, logic [TIME_W-1:0] t,
                                    int reps, bit typed, result_t res);
    plan_row_t row;
    row                   = '{default: '0};
    row.item.action       = act;
    row.item.queue_index  = q;
    row.item.client_id    = id;
    row.item.arrival_time = t;
    row.reps              = reps;
    row.typed             = typed;
    row.res               = res;
    plan.push_back(row);
  endfunction

  // Offers one item with a random lead gap, and records its expected result
  // at the edge where it is taken. Called and returns at a falling edge.
  task automatic send_item(item_t it, bit typed, result_t typed_res);
    result_t pred;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(it);
    do @(posedge clk); while (!in_tready);
    pred = predict_queue_op(it);
    expected_results.push_back(typed ? typed_res : pred);
    @(negedge clk);
  endtask

  // Writes queue_count once every outstanding result has come back.
  task automatic write_queue_count(logic [CNT_W-1:0] count);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= count;
    do @(posedge clk); while (!cfg_ready);
    shadow_count = int'(count);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic compare_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      mon_got = result_t'(out_tdata[$bits(result_t)-1:0]);
      if (expected_results.size() == 0) begin
        $error("result item with nothing pending: %h", mon_got);
        errors++;
      end else begin
        mon_want = expected_results.pop_front();
        compare_field("status", mon_want.status, mon_got.status);
        compare_field("head_valid", mon_want.head_valid, mon_got.head_valid);
        compare_field("head_id", mon_want.head_id, mon_got.head_id);
        compare_field("head_time", mon_want.head_time, mon_got.head_time);
        compare_field("queue_length", mon_want.queue_length, mon_got.queue_length);
      end
    end
  end

  // Result side back-pressure.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Stimulus.
  initial begin
    item_t            it;
    int               phase_count [6];
    int               phase_items [6];
    int               count;
    int               roll;
    int               hot;
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    errors       = 0;
    cycles       = 0;
    calm         = 1'b0;
    shadow_count = 0;
    foreach (shadow_len[i]) shadow_len[i] = 0;
    phase_count = '{16, 5, -1, 0, 16, 16};
    phase_items = '{300, 220, 220, 30, 300, 230};

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed table. No queue is valid straight after reset.
    plan_item(ACT_PEEK, 4'd0, 10'd0, 32'd0, 1, 1, mk_result(STAT_BADQ, 0, 0, 0, 0));
    plan_item(ACT_ADD, 4'd15, 10'd1023, 32'hFFFF_FFFF, 1, 1,
              mk_result(STAT_BADQ, 0, 0, 0, 0));
    plan_cfg(5'd16);
    plan_item(ACT_PEEK, 4'd0, 10'd0, 32'd0, 1, 1, mk_result(STAT_EMPTY, 0, 0, 0, 0));
    plan_item(ACT_PEEK_ALT, 4'd0, 10'd1023, 32'hFFFF_FFFF, 1, 1,
              mk_result(STAT_EMPTY, 0, 0, 0, 0));
    plan_item(ACT_REMOVE, 4'd0, 10'd5, 32'd0, 1, 1, mk_result(STAT_NOTFOUND, 0, 0, 0, 0));
    plan_item(ACT_ADD, 4'd0, 10'd1023, 32'hFFFF_FFFF, 1, 1,
              mk_result(STAT_DONE, 1, 10'd1023, 32'hFFFF_FFFF, 5'd1));
    plan_item(ACT_ADD, 4'd0, 10'd1023, 32'd0, 1, 1,
              mk_result(STAT_DUP, 1, 10'd1023, 32'hFFFF_FFFF, 5'd1));
    plan_item(ACT_ADD, 4'd0, 10'd0, 32'd0, 1, 0, '0);
    plan_item(ACT_REMOVE, 4'd0, 10'd1023, 32'd0, 1, 0, '0);
    plan_item(ACT_ADD, 4'd15, 10'd0, 32'h1234_5678, 1, 1,
              mk_result(STAT_DONE, 1, 10'd0, 32'h1234_5678, 5'd1));
    plan_item(ACT_REMOVE, 4'd15, 10'd0, 32'd0, 1, 1, mk_result(STAT_DONE, 0, 0, 0, 0));
    // Fill one list, then a full add wins over the duplicate check.
    plan_item(ACT_ADD, 4'd7, 10'd100, 32'd0, QUEUE_DEPTH, 0, '0);
    plan_item(ACT_ADD, 4'd7, 10'd100, 32'd77, 1, 1,
              mk_result(STAT_FULL, 1, 10'd100, 32'd0, 5'd16));
    plan_item(ACT_ADD, 4'd7, 10'd500, 32'd77, 1, 1,
              mk_result(STAT_FULL, 1, 10'd100, 32'd0, 5'd16));
    plan_item(ACT_REMOVE, 4'd7, 10'd108, 32'd0, 1, 0, '0);
    plan_item(ACT_REMOVE, 4'd7, 10'd100, 32'd0, 1, 0, '0);
    plan_item(ACT_PEEK, 4'd7, 10'd0, 32'd0, 1, 0, '0);
    plan_cfg(5'd1);
    plan_item(ACT_PEEK, 4'd1, 10'd0, 32'd0, 1, 1, mk_result(STAT_BADQ, 0, 0, 0, 0));
    plan_item(ACT_PEEK, 4'd0, 10'd0, 32'd0, 1, 0, '0);

    @(negedge clk);
    foreach (plan[r]) begin
      if (plan[r].is_cfg) begin
        write_queue_count(plan[r].count);
      end else begin
        for (int k = 0; k < plan[r].reps; k++) begin
          it              = plan[r].item;
          it.client_id    = it.client_id + ID_BITS'(k);
          it.arrival_time = it.arrival_time + TIME_W'(k);
          send_item(it, plan[r].typed, plan[r].res);
        end
      end
    end

    // Random phases: ids from a small pool so duplicates, hits and full
    // lists are common, with most traffic on a few hot queues.
    for (int p = 0; p < 6; p++) begin
      count = (phase_count[p] < 0) ? $urandom_range(1, 15) : phase_count[p];
      write_queue_count(CNT_W'(count));
      calm = (p == 4);
      hot  = (count > 3) ? 3 : count;
      for (int n = 0; n < phase_items[p]; n++) begin
        roll = $urandom_range(99);
        if (roll < 45)      it.action = ACT_ADD;
        else if (roll < 75) it.action = ACT_REMOVE;
        else if (roll < 92) it.action = ACT_PEEK;
        else                it.action = ACT_PEEK_ALT;
        roll = $urandom_range(99);
        if (count > 0 && roll < 60)
          it.queue_index = QIDX_W'($urandom_range(0, hot - 1));
        else if (count > 0 && roll < 90)
          it.queue_index = QIDX_W'($urandom_range(0, count - 1));
        else
          it.queue_index = QIDX_W'($urandom_range(0, NUM_QUEUES - 1));
        roll = $urandom_range(99);
        it.client_id = (roll < 80) ? ID_BITS'($urandom_range(0, 23))
                                   : ID_BITS'($urandom_range(0, 1023));
        roll = $urandom_range(99);
        if (roll < 5)       it.arrival_time = '0;
        else if (roll < 10) it.arrival_time = '1;
        else                it.arrival_time = $urandom;
        send_item(it, 1'b0, '0);
      end
      calm = 1'b0;
    end

    // Drain and let the block settle.
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      if (expected_results.size() != 0)
        $error("%0d expected results never arrived", expected_results.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
